// ----- rtl/mvct_pkg.sv -----
// ----------------------------------------------------------------------------
// mvct_pkg
// Shared types and constants for the mesh volume chunk triangulator.
// ----------------------------------------------------------------------------
package mvct_pkg;

  localparam logic [7:0] KIND_TRI  = 8'd56;
  localparam logic [7:0] KIND_QUAD = 8'd57;

  localparam logic REG_PRIM_KIND     = 1'b0;
  localparam logic REG_LITTLE_ENDIAN = 1'b1;

  typedef enum logic [1:0] {
    CAND_POLY0,
    CAND_POLY1,
    CAND_STRIP,
    CAND_OVF
  } cand_sel_t;

  typedef struct packed {
    logic      accept;
    logic      k_clr;
    logic      rd_en;
    logic      shift;
    logic      k_inc;
    logic      cand_en;
    cand_sel_t cand_sel;
    logic      flush;
  } dp_cmd_t;

  typedef struct packed {
    logic fin_poly;
    logic fin_strip;
    logic job_quad;
    logic strip_ovf;
    logic strip_short;
    logic k_lt2;
    logic k_last;
    logic pend_valid;
    logic slot_free;
  } dp_stat_t;

endpackage

// ----- rtl/mvct_ram.sv -----
// ----------------------------------------------------------------------------
// mvct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mvct_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/mvct_dp.sv -----
// ----------------------------------------------------------------------------
// mvct_dp
// Datapath: word parser, corner and strip storage, triangle candidates,
// one-deep pending stage and the output register.
// ----------------------------------------------------------------------------
module mvct_dp
  import mvct_pkg::*;
#(
  parameter int MAX_STRIP = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic [15:0] raw_word,
  input  logic        first_word,
  input  logic        last_word,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [14:0] vert_a,
  output logic [14:0] vert_b,
  output logic [14:0] vert_c,
  output logic        item_kind,
  output logic        run_end,
  output logic [15:0] triangle_count
);

  localparam int AW = (MAX_STRIP > 1) ? $clog2(MAX_STRIP) : 1;
  localparam int KW = $clog2(MAX_STRIP + 1);

  typedef enum logic [2:0] {
    PH_IDLE, PH_NEXT, PH_POLY, PH_SKIP_TRI, PH_SKIP_QUAD, PH_SIDX, PH_SSKIP, PH_DONE
  } phase_t;

  logic [7:0]  prim_kind;
  logic        little_endian;
  phase_t      phase, phase_next, ph;
  logic [13:0] prims_left, prims_left_next, pl_dec;
  logic [1:0]  user_words, user_words_next;
  logic [2:0]  word_in_prim, word_in_prim_next, wip_cur, wip_inc, wip_dec;
  logic [14:0] corner_regs [4];
  logic [14:0] strip_len, strip_len_next;
  logic [14:0] strip_seen, strip_seen_next, seen_inc;
  logic        strip_reverse, strip_reverse_next;
  logic [15:0] tri_total;
  logic        total_clr, corner_we, store_we, prim_end;
  logic [1:0]  corner_sel;
  logic        fin_poly, fin_quad, fin_strip, job_quad;
  logic [15:0] w;
  logic [14:0] idx;
  logic        is_poly_kind;

  logic [KW-1:0] k;
  logic [14:0]   w0, w1, rdata;

  logic [14:0] ca, cb, cc;
  logic        c_ovf, c_ok;
  logic [15:0] tri_inc;

  logic        pend_valid;
  logic [14:0] pa, pb, pc;
  logic        pkind;
  logic [15:0] pcount;
  logic        push;

  assign w            = little_endian ? raw_word : {raw_word[7:0], raw_word[15:8]};
  assign idx          = w[14:0];
  assign pl_dec       = prims_left - 14'd1;
  assign seen_inc     = strip_seen + 15'd1;
  assign wip_dec      = word_in_prim - 3'd1;
  assign is_poly_kind = (prim_kind == KIND_TRI) || (prim_kind == KIND_QUAD);

  always_comb begin
    phase_next         = phase;
    prims_left_next    = prims_left;
    user_words_next    = user_words;
    word_in_prim_next  = word_in_prim;
    strip_len_next     = strip_len;
    strip_seen_next    = strip_seen;
    strip_reverse_next = strip_reverse;
    total_clr          = 1'b0;
    corner_we          = 1'b0;
    store_we           = 1'b0;
    prim_end           = 1'b0;
    fin_poly           = 1'b0;
    fin_quad           = 1'b0;
    fin_strip          = 1'b0;
    wip_cur            = word_in_prim;
    wip_inc            = word_in_prim + 3'd1;
    corner_sel         = word_in_prim[1:0];
    ph                 = phase;
    if (first_word) begin
      user_words_next   = w[15:14];
      prims_left_next   = w[13:0];
      total_clr         = 1'b1;
      word_in_prim_next = 3'd0;
      phase_next        = (w[13:0] == 14'd0 || last_word) ? PH_DONE : PH_NEXT;
    end else if (phase != PH_IDLE && phase != PH_DONE) begin
      if (phase == PH_NEXT) begin
        word_in_prim_next = 3'd0;
        wip_cur           = 3'd0;
        if (is_poly_kind) begin
          ph = PH_POLY;
        end else begin
          strip_reverse_next = w[15];
          strip_len_next     = idx;
          strip_seen_next    = 15'd0;
          if (idx == 15'd0) begin
            prim_end = 1'b1;
          end else begin
            phase_next = PH_SIDX;
          end
        end
      end
      case (ph)
        PH_POLY: begin
          corner_we  = 1'b1;
          corner_sel = wip_cur[1:0];
          wip_inc    = wip_cur + 3'd1;
          if (wip_inc >= ((prim_kind == KIND_QUAD) ? 3'd4 : 3'd3)) begin
            if (user_words == 2'd0) begin
              fin_poly = 1'b1;
              fin_quad = (wip_inc >= 3'd4);
              prim_end = 1'b1;
            end else begin
              word_in_prim_next = {1'b0, user_words};
              phase_next = (wip_inc >= 3'd4) ? PH_SKIP_QUAD : PH_SKIP_TRI;
            end
          end else begin
            word_in_prim_next = wip_inc;
            phase_next        = PH_POLY;
          end
        end
        PH_SKIP_TRI, PH_SKIP_QUAD: begin
          word_in_prim_next = wip_dec;
          if (wip_dec == 3'd0) begin
            fin_poly = 1'b1;
            fin_quad = (ph == PH_SKIP_QUAD);
            prim_end = 1'b1;
          end
        end
        PH_SIDX: begin
          store_we        = (strip_seen < 15'(MAX_STRIP));
          strip_seen_next = seen_inc;
          if (seen_inc >= 15'd3 && user_words != 2'd0) begin
            word_in_prim_next = {1'b0, user_words};
            phase_next        = PH_SSKIP;
          end else if (seen_inc >= strip_len) begin
            fin_strip = 1'b1;
            prim_end  = 1'b1;
          end
        end
        PH_SSKIP: begin
          word_in_prim_next = wip_dec;
          if (wip_dec == 3'd0) begin
            if (strip_seen >= strip_len) begin
              fin_strip = 1'b1;
              prim_end  = 1'b1;
            end else begin
              phase_next = PH_SIDX;
            end
          end
        end
        default: begin
        end
      endcase
      if (prim_end) begin
        prims_left_next = pl_dec;
        phase_next      = (pl_dec == 14'd0) ? PH_DONE : PH_NEXT;
      end
      if (last_word) begin
        phase_next = PH_DONE;
      end
    end
  end

  // Strip index store
  mvct_ram #(
    .WIDTH(15),
    .DEPTH(MAX_STRIP)
  ) u_store (
    .clk  (clk),
    .we   (cmd.accept && store_we),
    .waddr(strip_seen[AW-1:0]),
    .wdata(idx),
    .re   (cmd.rd_en),
    .raddr(k[AW-1:0]),
    .rdata(rdata)
  );

  // Triangle candidate
  always_comb begin
    c_ovf = 1'b0;
    ca    = corner_regs[0];
    cb    = corner_regs[1];
    cc    = corner_regs[2];
    case (cmd.cand_sel)
      CAND_POLY0: begin
      end
      CAND_POLY1: begin
        cb = corner_regs[2];
        cc = corner_regs[3];
      end
      CAND_STRIP: begin
        if (k[0] ^ strip_reverse) begin
          ca = w1;
          cb = w0;
        end else begin
          ca = w0;
          cb = w1;
        end
        cc = rdata;
      end
      CAND_OVF: begin
        c_ovf = 1'b1;
        ca    = 15'd0;
        cb    = 15'd0;
        cc    = 15'd0;
      end
      default: begin
      end
    endcase
  end

  assign c_ok    = c_ovf || (ca != cb && cb != cc && ca != cc);
  assign tri_inc = (tri_total == 16'hFFFF) ? tri_total : tri_total + 16'd1;
  assign push    = (cmd.cand_en && c_ok && pend_valid) || (cmd.flush && pend_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      prim_kind     <= 8'd0;
      little_endian <= 1'b1;
      phase         <= PH_IDLE;
      prims_left    <= 14'd0;
      user_words    <= 2'd0;
      word_in_prim  <= 3'd0;
      strip_len     <= 15'd0;
      strip_seen    <= 15'd0;
      strip_reverse <= 1'b0;
      tri_total     <= 16'd0;
      job_quad      <= 1'b0;
      k             <= '0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PRIM_KIND:     prim_kind <= cfg_data;
          REG_LITTLE_ENDIAN: little_endian <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (cmd.accept) begin
        phase         <= phase_next;
        prims_left    <= prims_left_next;
        user_words    <= user_words_next;
        word_in_prim  <= word_in_prim_next;
        strip_len     <= strip_len_next;
        strip_seen    <= strip_seen_next;
        strip_reverse <= strip_reverse_next;
        job_quad      <= fin_quad;
        if (total_clr) begin
          tri_total <= 16'd0;
        end
      end
      if (cmd.k_clr) begin
        k <= '0;
      end else if (cmd.k_inc) begin
        k <= k + KW'(1);
      end
      if (cmd.cand_en && c_ok) begin
        pend_valid <= 1'b1;
        if (!c_ovf) begin
          tri_total <= tri_inc;
        end
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && corner_we) begin
      corner_regs[corner_sel] <= idx;
    end
    if (cmd.shift) begin
      w0 <= w1;
      w1 <= rdata;
    end
    if (cmd.cand_en && c_ok) begin
      pa     <= ca;
      pb     <= cb;
      pc     <= cc;
      pkind  <= c_ovf;
      pcount <= c_ovf ? tri_total : tri_inc;
    end
    if (push) begin
      vert_a         <= pa;
      vert_b         <= pb;
      vert_c         <= pc;
      item_kind      <= pkind;
      triangle_count <= pcount;
      run_end        <= cmd.flush;
    end
  end

  assign stat.fin_poly    = fin_poly;
  assign stat.fin_strip   = fin_strip;
  assign stat.job_quad    = job_quad;
  assign stat.strip_ovf   = (strip_len > 15'(MAX_STRIP));
  assign stat.strip_short = (strip_len < 15'd3);
  assign stat.k_lt2       = (k < KW'(2));
  assign stat.k_last      = (15'(k) + 15'd1 == strip_len);
  assign stat.pend_valid  = pend_valid;
  assign stat.slot_free   = !out_valid || !out_stall;

endmodule

// ----- rtl/mvct_ctrl.sv -----
// ----------------------------------------------------------------------------
// mvct_ctrl
// Controller: accepts words, then sequences triangle emission per primitive.
// ----------------------------------------------------------------------------
module mvct_ctrl
  import mvct_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_POLY0, S_POLY1, S_OVF, S_SRD, S_SUSE, S_FLUSH
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.cand_sel = CAND_POLY0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.fin_poly) begin
            state_next = S_POLY0;
          end else if (stat.fin_strip) begin
            cmd.k_clr = 1'b1;
            if (stat.strip_ovf) begin
              state_next = S_OVF;
            end else if (!stat.strip_short) begin
              state_next = S_SRD;
            end
          end
        end
      end
      S_POLY0: begin
        cmd.cand_sel = CAND_POLY0;
        if (stat.slot_free) begin
          cmd.cand_en = 1'b1;
          state_next  = stat.job_quad ? S_POLY1 : S_FLUSH;
        end
      end
      S_POLY1: begin
        cmd.cand_sel = CAND_POLY1;
        if (stat.slot_free) begin
          cmd.cand_en = 1'b1;
          state_next  = S_FLUSH;
        end
      end
      S_OVF: begin
        cmd.cand_sel = CAND_OVF;
        if (stat.slot_free) begin
          cmd.cand_en = 1'b1;
          state_next  = S_FLUSH;
        end
      end
      S_SRD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_SUSE;
      end
      S_SUSE: begin
        cmd.cand_sel = CAND_STRIP;
        if (stat.k_lt2) begin
          cmd.shift  = 1'b1;
          cmd.k_inc  = 1'b1;
          state_next = S_SRD;
        end else if (stat.slot_free) begin
          cmd.cand_en = 1'b1;
          cmd.shift   = 1'b1;
          cmd.k_inc   = 1'b1;
          state_next  = stat.k_last ? S_FLUSH : S_SRD;
        end
      end
      S_FLUSH: begin
        if (!stat.pend_valid) begin
          state_next = S_IDLE;
        end else if (stat.slot_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/mesh_volume_chunk_triangulator_core.sv -----
// ----------------------------------------------------------------------------
// mesh_volume_chunk_triangulator_core
// Turns the words of a mesh volume chunk into a list of triangles.
// ----------------------------------------------------------------------------
//  channel | signals                                         | direction
//  input   | in_valid, in_stall, raw_word, first/last_word   | into block
//  output  | out_valid, out_stall, vert_a/b/c, item_kind,    | out of block
//          | run_end, triangle_count                         |
//  config  | cfg_we, cfg_index, cfg_data                     | into block
//
// A word that emits nothing leaves the controller idle. A finished triangle or
// quad takes one candidate state per triangle, then S_FLUSH. A finished strip
// takes S_SRD and S_SUSE per index, then S_FLUSH: the strip store has one read
// port with registered data, so each index costs an address and a use step. A
// long strip takes S_OVF, then S_FLUSH. Synchronous reset returns to idle with
// no chunk open; no clearing pass. Output stalls hold the emission sequence.
// ----------------------------------------------------------------------------
module mesh_volume_chunk_triangulator_core
  import mvct_pkg::*;
#(
  parameter int MAX_STRIP = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] raw_word,
  input  logic        first_word,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] vert_a,
  output logic [14:0] vert_b,
  output logic [14:0] vert_c,
  output logic        item_kind,
  output logic        run_end,
  output logic [15:0] triangle_count,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  // Controller to datapath commands, and status back
  dp_cmd_t  cmd;
  dp_stat_t stat;

  mvct_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Parser state, strip store, pending triangle and output register
  mvct_dp #(
    .MAX_STRIP(MAX_STRIP)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .raw_word      (raw_word),
    .first_word    (first_word),
    .last_word     (last_word),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .vert_a        (vert_a),
    .vert_b        (vert_b),
    .vert_c        (vert_c),
    .item_kind     (item_kind),
    .run_end       (run_end),
    .triangle_count(triangle_count)
  );

endmodule

// ----- rtl/mvct_checker.sv -----
// ----------------------------------------------------------------------------
// mvct_checker
// Port-level checks for the triangulator core, bound to the top level.
// ----------------------------------------------------------------------------
module mvct_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [14:0] vert_a,
  input logic [14:0] vert_b,
  input logic [14:0] vert_c,
  input logic        item_kind,
  input logic [15:0] triangle_count
);

  // Hold a stalled result transaction
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(vert_a) && $stable(vert_b)
      && $stable(vert_c) && $stable(triangle_count))
    else $error("stalled result changed");

  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind |-> vert_a == 15'd0 && vert_b == 15'd0 && vert_c == 15'd0)
    else $error("overflow result with nonzero vertices");

  a_nondegen: assert property (@(posedge clk) disable iff (rst)
    out_valid && !item_kind |-> vert_a != vert_b && vert_b != vert_c && vert_a != vert_c)
    else $error("degenerate triangle emitted");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !item_kind |-> triangle_count != 16'd0)
    else $error("triangle with zero count");

endmodule

bind mesh_volume_chunk_triangulator_core mvct_checker u_mvct_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .vert_a        (vert_a),
  .vert_b        (vert_b),
  .vert_c        (vert_c),
  .item_kind     (item_kind),
  .triangle_count(triangle_count)
);

// ----- bench/mesh_volume_chunk_triangulator_core_test.sv -----
// ----------------------------------------------------------------------------
// mesh_volume_chunk_triangulator_core_test
// Self-checking bench: feeds chunk words (triangles, quads, strips) under
// varied settings and idling, predicts the triangle list, checks every result.
// ----------------------------------------------------------------------------
module mesh_volume_chunk_triangulator_core_test
  import mvct_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STRIP_DEPTH = 64;
  localparam int SETTLE      = 160;
  localparam int WATCHDOG    = 20000;

  typedef enum int {
    PS_IDLE, PS_NEXT, PS_POLY, PS_SKIP_TRI, PS_SKIP_QUAD, PS_SIDX, PS_SSKIP, PS_DONE
  } parse_t;

  typedef struct packed {
    logic [14:0] a;
    logic [14:0] b;
    logic [14:0] c;
    logic        kind;
    logic        fin;
    logic [15:0] cnt;
  } tri_rec_t;

  // Predicts the triangle list and keeps the triangles still owed by the block.
  class tri_scoreboard;
    bit [7:0]    kind;
    bit          le;
    parse_t      ph;
    int unsigned left, uw, wip, slen, sseen, total;
    bit          srev;
    bit [14:0]   corner [4];
    bit [14:0]   sbuf [STRIP_DEPTH];
    tri_rec_t    owed [$];
    int          errors, checked, words, overflows;

    function new();
      kind = 8'd0;
      le = 1'b1;
      ph = PS_IDLE;
      left = 0; uw = 0; wip = 0; slen = 0; sseen = 0; total = 0; srev = 0;
      errors = 0; checked = 0; words = 0; overflows = 0;
    endfunction

    function void emit(bit [14:0] a, bit [14:0] b, bit [14:0] c, bit k);
      tri_rec_t r;
      r.a = a; r.b = b; r.c = c; r.kind = k; r.fin = 1'b0; r.cnt = total[15:0];
      owed.insert(owed.size(), r);
    endfunction

    function void add_tri(bit [14:0] a, bit [14:0] b, bit [14:0] c);
      if (a == b || b == c || a == c) return;
      if (total < 65535) total++;
      emit(a, b, c, 1'b0);
    endfunction

    function void finish_poly(bit quad);
      add_tri(corner[0], corner[1], corner[2]);
      if (quad) add_tri(corner[0], corner[2], corner[3]);
    endfunction

    function void finish_strip();
      bit [14:0] a, b, c, t;
      if (slen > STRIP_DEPTH) begin
        emit(15'd0, 15'd0, 15'd0, 1'b1);
        return;
      end
      for (int unsigned i = 2; i < slen; i++) begin
        a = sbuf[i-2]; b = sbuf[i-1]; c = sbuf[i];
        // odd triangles flip winding, reverse flag inverts the parity
        if ((i[0] ^ srev) != 1'b0) begin
          t = a; a = b; b = t;
        end
        add_tri(a, b, c);
      end
    endfunction

    function void prim_done();
      left = (left - 1) & 32'h3FFF;
      ph = (left == 0) ? PS_DONE : PS_NEXT;
    endfunction

    function void finish_strip_or_next();
      if (sseen >= slen) begin
        finish_strip();
        prim_done();
      end else begin
        ph = PS_SIDX;
      end
    endfunction

    // Note one accepted chunk word and queue the triangles it releases.
    function void note_word(bit [15:0] raw, bit first, bit last);
      bit [15:0]   w;
      bit [14:0]   idx;
      int unsigned n0, need;
      bit          hdr_only;
      words++;
      n0 = owed.size();
      w = le ? raw : {raw[7:0], raw[15:8]};
      idx = w[14:0];
      hdr_only = 1'b0;
      if (first) begin
        uw = w[15:14];
        left = w[13:0];
        total = 0;
        wip = 0;
        ph = (left == 0 || last) ? PS_DONE : PS_NEXT;
        return;
      end
      if (ph == PS_IDLE || ph == PS_DONE) return;
      if (ph == PS_NEXT) begin
        wip = 0;
        if (kind == KIND_TRI || kind == KIND_QUAD) begin
          ph = PS_POLY;
        end else begin
          srev = w[15];
          slen = idx;
          sseen = 0;
          hdr_only = 1'b1;
          if (slen == 0) prim_done();
          else ph = PS_SIDX;
        end
      end
      if (!hdr_only) begin
        case (ph)
          PS_POLY: begin
            need = (kind == KIND_QUAD) ? 4 : 3;
            corner[wip & 3] = idx;
            wip = (wip + 1) & 7;
            if (wip >= need) begin
              if (uw == 0) begin
                finish_poly(wip >= 4);
                prim_done();
              end else begin
                ph = (wip >= 4) ? PS_SKIP_QUAD : PS_SKIP_TRI;
                wip = uw;
              end
            end
          end
          PS_SKIP_TRI, PS_SKIP_QUAD: begin
            wip = (wip - 1) & 7;
            if (wip == 0) begin
              finish_poly(ph == PS_SKIP_QUAD);
              prim_done();
            end
          end
          PS_SIDX: begin
            if (sseen < STRIP_DEPTH) sbuf[sseen] = idx;
            sseen = (sseen + 1) & 32'h7FFF;
            if (sseen >= 3 && uw != 0) begin
              wip = uw;
              ph = PS_SSKIP;
            end else begin
              finish_strip_or_next();
            end
          end
          PS_SSKIP: begin
            wip = (wip - 1) & 7;
            if (wip == 0) finish_strip_or_next();
          end
          default: ;
        endcase
      end
      if (last) ph = PS_DONE;
      if (owed.size() > n0) owed[owed.size()-1].fin = 1'b1;
    endfunction

    function void mismatch(string what);
      errors++;
      if (errors <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_tri(tri_rec_t got);
      tri_rec_t exp_r;
      checked++;
      if (got.kind) overflows++;
      if (owed.size() == 0) begin
        mismatch($sformatf("unexpected result a=%0d b=%0d c=%0d kind=%0d",
                           got.a, got.b, got.c, got.kind));
        return;
      end
      exp_r = owed.pop_front();
      if (got.a != exp_r.a) mismatch($sformatf("vert_a exp %0d got %0d", exp_r.a, got.a));
      if (got.b != exp_r.b) mismatch($sformatf("vert_b exp %0d got %0d", exp_r.b, got.b));
      if (got.c != exp_r.c) mismatch($sformatf("vert_c exp %0d got %0d", exp_r.c, got.c));
      if (got.kind != exp_r.kind)
        mismatch($sformatf("item_kind exp %0d got %0d", exp_r.kind, got.kind));
      if (got.fin != exp_r.fin)
        mismatch($sformatf("run_end exp %0d got %0d", exp_r.fin, got.fin));
      if (got.cnt != exp_r.cnt)
        mismatch($sformatf("triangle_count exp %0d got %0d", exp_r.cnt, got.cnt));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] raw_word;
  logic        first_word;
  logic        last_word;
  logic        out_valid;
  logic        out_stall;
  logic [14:0] vert_a, vert_b, vert_c;
  logic        item_kind;
  logic        run_end;
  logic [15:0] triangle_count;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  tri_scoreboard sb = new();
  int            gap_pct = 0;    // chance the sender idles in a cycle
  int            stall_pct = 0;  // chance the receiver stalls in a cycle
  int            quiet_cycles = 0;

  mesh_volume_chunk_triangulator_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .raw_word(raw_word), .first_word(first_word), .last_word(last_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .vert_a(vert_a), .vert_b(vert_b), .vert_c(vert_c),
    .item_kind(item_kind), .run_end(run_end), .triangle_count(triangle_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receive side: check each result transaction, randomize the stall and
  // watch for a hang (no transaction on either channel for too long).
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_tri({vert_a, vert_b, vert_c, item_kind, run_end, triangle_count});
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
          $display("timeout with %0d results outstanding", sb.owed.size());
          $display("[mesh_volume_chunk_triangulator_core] ERROR");
          $finish;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Offer one chunk word (logical value, byte-swapped here when big endian);
  // hold it until the block takes it, then note the transaction.
  task automatic send_word(input logic [15:0] w, input bit first, input bit last);
    logic [15:0] raw;
    raw = sb.le ? w : {w[7:0], w[15:8]};
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    raw_word   <= raw;
    first_word <= first;
    last_word  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(raw, first, last);
  endtask

  // Wait for all owed results, then let trailing no-result words settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_PRIM_KIND) sb.kind = data;
    else sb.le = data[0];
  endtask

  function automatic logic [15:0] pick_index();
    // favor a few small values so degenerate triangles show up
    if ($urandom_range(0, 9) < 3) return 16'($urandom_range(0, 3));
    return {$urandom_range(0, 1) == 1, 15'($urandom_range(0, 32767))};
  endfunction

  // Build one chunk for the current kind, mostly well formed, then maybe break it.
  task automatic random_chunk(inout int sent);
    logic [15:0] q[$];
    int unsigned uw, n, len, cut;
    int          mode;
    bit          mark_last;
    uw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    n = $urandom_range(1, 4);
    if ($urandom_range(0, 19) == 0) q.insert(q.size(), {2'(uw), 14'($urandom_range(0, 16383))});
    else q.insert(q.size(), {2'(uw), 14'(n)});
    for (int p = 0; p < n; p++) begin
      if (sb.kind == KIND_TRI || sb.kind == KIND_QUAD) begin
        repeat ((sb.kind == KIND_QUAD) ? 4 : 3) q.insert(q.size(), pick_index());
        repeat (uw) q.insert(q.size(), 16'($urandom));
      end else begin
        case ($urandom_range(0, 19))
          0:       len = $urandom_range(65, 70);
          1:       len = $urandom_range(30, 64);
          default: len = $urandom_range(0, 7);
        endcase
        q.insert(q.size(), {1'($urandom_range(0, 1)), 15'(len)});
        for (int v = 0; v < len; v++) begin
          q.insert(q.size(), pick_index());
          if (v >= 2) repeat (uw) q.insert(q.size(), 16'($urandom));
        end
      end
    end
    mark_last = 1'b1;
    mode = $urandom_range(0, 9);
    if (mode == 0 && q.size() > 2) begin
      // cut short inside the chunk
      cut = $urandom_range(1, q.size() - 2);
      while (q.size() > cut + 1) void'(q.pop_back());
    end else if (mode == 1) begin
      // no end mark, trailing noise past the count
      mark_last = 1'b0;
      repeat (2) q.insert(q.size(), 16'($urandom));
    end else if (mode == 2 && q.size() > 2) begin
      // abandoned mid-chunk: the next header takes over
      mark_last = 1'b0;
      cut = $urandom_range(1, q.size() - 2);
      while (q.size() > cut + 1) void'(q.pop_back());
    end
    foreach (q[i]) send_word(q[i], i == 0, mark_last && (i == q.size() - 1));
    sent += q.size();
  endtask

  initial begin
    logic [7:0] kinds [5];
    int         sent;
    int         sub;
    rst        = 1'b1;
    in_valid   = 1'b0;
    raw_word   = '0;
    first_word = 1'b0;
    last_word  = 1'b0;
    out_stall  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_PRIM_KIND;
    cfg_data   = '0;
    kinds      = '{KIND_TRI, KIND_QUAD, 8'd0, 8'd255, 8'd0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings select strips, words in little-endian order.
    send_word(16'h1234, 0, 0);           // no chunk open yet: ignored
    send_word(16'h0000, 1, 0);           // empty chunk
    send_word(16'hFFFF, 0, 0);           // ignored
    send_word(16'h0005, 1, 1);           // header that is also the end
    send_word(16'h0005, 1, 0);
    send_word(16'h0000, 0, 0);           // zero-length strip
    send_word(16'h0001, 0, 0);
    send_word(16'h7FFF, 0, 0);           // one-vertex strip
    send_word(16'h8004, 0, 0);           // reversed strip of four
    send_word(16'h0000, 0, 0);
    send_word(16'h7FFF, 0, 0);
    send_word(16'h0001, 0, 0);
    send_word(16'h0001, 0, 0);           // last triangle degenerate
    send_word(16'h0002, 0, 0);
    send_word(16'h0009, 0, 0);
    send_word(16'h0009, 0, 1);           // two-vertex strip completes on last
    drain();
    // Quads with one user word, then a quad cut short.
    write_reg(REG_PRIM_KIND, KIND_QUAD);
    send_word(16'h4002, 1, 0);
    send_word(16'h0001, 0, 0);
    send_word(16'h0002, 0, 0);
    send_word(16'h0003, 0, 0);
    send_word(16'h0004, 0, 0);
    send_word(16'hFFFF, 0, 0);
    send_word(16'h0005, 0, 0);
    send_word(16'h0006, 0, 1);
    // Kind switched from quad to triangle mid-primitive.
    send_word(16'h0001, 1, 0);
    send_word(16'h000A, 0, 0);
    send_word(16'h000B, 0, 0);
    drain();
    write_reg(REG_PRIM_KIND, KIND_TRI);
    send_word(16'h000C, 0, 1);
    // Triangles with extremes and a degenerate one; then a header mid-chunk.
    send_word(16'h0002, 1, 0);
    send_word(16'h7FFF, 0, 0);
    send_word(16'h0000, 0, 0);
    send_word(16'h0005, 0, 0);
    send_word(16'h0003, 0, 0);
    send_word(16'h0003, 0, 0);
    send_word(16'h0004, 0, 0);
    send_word(16'h0003, 1, 0);
    send_word(16'h0001, 0, 0);
    send_word(16'h0001, 1, 0);           // abandons the open triangle
    send_word(16'h0004, 0, 0);
    send_word(16'h0005, 0, 0);
    send_word(16'h0006, 0, 1);
    drain();

    // Random: four idling phases, each with three register settings.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 87; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 87; end
        default: begin gap_pct = 32; stall_pct = 32; end
      endcase
      for (int s = 0; s < 3; s++) begin
        sub = ph * 3 + s;
        kinds[4] = 8'($urandom_range(0, 255));
        write_reg(REG_PRIM_KIND, kinds[sub % 5]);
        write_reg(REG_LITTLE_ENDIAN, {7'($urandom_range(0, 127)), 1'(sub % 2)});
        sent = 0;
        while (sent < 28) random_chunk(sent);
        drain();
      end
    end
    gap_pct = 0;
    stall_pct = 0;
    drain();

    $display("covered %0d chunk words, %0d results checked (%0d long-strip drops)",
             sb.words, sb.checked, sb.overflows);
    $display("mismatches: %0d, results still owed: %0d", sb.errors, sb.owed.size());
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("[mesh_volume_chunk_triangulator_core] OK");
    end else begin
      $display("[mesh_volume_chunk_triangulator_core] ERROR");
    end
    $finish;
  end

endmodule
